// ===== rtl/twc_pkg.sv =====
`default_nettype none
package twc_pkg;
    localparam int SETS = 4;
    localparam int WAYS = 2;
    localparam int LINE_WORDS = 8;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LINES = SETS * WAYS;
    localparam int LINE_W = $clog2(LINES);
    localparam int WORDS = LINES * LINE_WORDS;
    localparam int WADDR_W = $clog2(WORDS);
    localparam int TAG_W = 9;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WDONE = 3'd1;
    localparam logic [2:0] KIND_FREQ  = 3'd2;
    localparam logic [2:0] KIND_WB    = 3'd3;
    localparam logic [2:0] KIND_FDONE = 3'd4;
    localparam logic [2:0] KIND_MIS   = 3'd5;
    localparam logic [2:0] KIND_PROT  = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [31:0] write_data;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_WB, ST_FLUSH_SCAN, ST_FILL_RD, ST_OUT
    } state_t;

    function automatic logic [SET_W-1:0] set_of(input logic [15:0] a);
        set_of = SET_W'(32'(a[6:5]) % SETS);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/two_way_write_back_cache_top.sv =====
`default_nettype none
// two-way, four-set write-back cache with 32-byte lines and lru replacement
// input channel: in_valid/in_ready carries command, address, write_data
// output channel: out_valid/out_ready carries kind, line_address, data,
//   hit, compulsory, last; last marks the final result of one transaction
// a two-entry queue parts the front (accept) from the engine (execute)
// a hit, misaligned or error transaction passes accept, lookup, output
//   staging and the output register; the engine takes a new transaction
//   only when idle with its output register empty
// a fill word other than the eighth gives no result; the eighth also
//   passes an extra read or store of the word before output staging
// a dirty miss streams eight writeback words, one a cycle while the
//   receiver is ready, then the fill request; flush scans the eight lines,
//   one per cycle between writebacks, and streams out each dirty line
// the word memory has one write and one registered read port
// at reset valid, dirty and lru bits clear and no fill is pending
// when the receiver stalls the result holds in the output register and the
//   engine waits; the queue keeps accepting until it is full
module two_way_write_back_cache_top
    import twc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [15:0]      line_address,
    output logic [31:0]      data,
    output logic             hit,
    output logic             compulsory,
    output logic             last
);
    req_t in_req, q_req;
    logic q_valid, q_ready;

    assign in_req = '{command: command, address: address, write_data: write_data};

    // front: transaction queue
    twc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
    );

    // back: lookup, fill, writeback and flush sequencing
    twc_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .line_address(line_address), .data(data),
        .hit(hit), .compulsory(compulsory), .last(last)
    );
endmodule
`default_nettype wire

// ===== rtl/twc_queue.sv =====
`default_nettype none
module twc_queue
    import twc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output req_t      out_data
);
    req_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    logic push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk) begin
        if (push) begin
            q_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("count range");
endmodule
`default_nettype wire

// ===== rtl/twc_engine.sv =====
`default_nettype none
module twc_engine
    import twc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [2:0] kind,
    output logic [15:0] line_address,
    output logic [31:0] data,
    output logic       hit,
    output logic       compulsory,
    output logic       last
);
    logic [31:0] mem [WORDS];
    logic [31:0] rd_reg;
    logic [TAG_W-1:0] tag_reg [LINES];
    logic [LINES-1:0] valid_reg, dirty_reg;
    logic [SETS-1:0] lru_reg;

    logic p_act_reg, p_wr_reg, p_way_reg, p_comp_reg;
    logic [15:0] p_addr_reg;
    logic [31:0] p_data_reg;
    logic [2:0] fcnt_reg;

    state_t st_reg, st_next;
    req_t cur_reg;
    logic [LINE_W-1:0] wbl_reg;
    logic [2:0] wbi_reg;
    logic wb_flush_reg;
    logic [LINE_W:0] scan_reg;
    logic any_reg;

    // staged result, moved to the output register from ST_OUT
    logic [2:0] sk_reg;
    logic [15:0] sla_reg;
    logic sdm_reg, sh_reg, sc_reg;

    logic ov_reg, ov_next;
    logic [2:0] ok_reg;
    logic [15:0] ola_reg;
    logic oh_reg, oc_reg, ol_reg, od_mem_reg;

    logic [SET_W-1:0] cset, pset;
    logic [TAG_W-1:0] ctag;
    logic [LINE_W-1:0] l0, l1, hl, vl;
    logic h0, h1, vw, cmp;
    logic [LINE_W-1:0] pline;
    logic [LINE_W-1:0] sline;
    logic is_fill, is_prot, fill_mid, fill_end, is_flush, is_mis, is_access;
    logic is_hit, is_miss, victim_dirty;
    logic scan_done, scan_dirty, more, wb_end;
    logic slot_free;

    // memory port control
    logic mem_we;
    logic [WADDR_W-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;
    logic mem_re;

    assign cset = set_of(cur_reg.address);
    assign ctag = cur_reg.address[15:7];
    assign l0 = LINE_W'({cset, 1'b0});
    assign l1 = LINE_W'({cset, 1'b1});
    assign h0 = valid_reg[l0] && tag_reg[l0] == ctag;
    assign h1 = valid_reg[l1] && tag_reg[l1] == ctag;
    assign hl = h0 ? l0 : l1;
    assign pset = set_of(p_addr_reg);
    assign pline = LINE_W'({pset, p_way_reg});
    assign sline = scan_reg[LINE_W-1:0];

    // classification of the transaction under lookup
    assign is_fill = cur_reg.command == CMD_FILL;
    assign is_prot = is_fill ? !p_act_reg : p_act_reg;
    assign fill_mid = is_fill && p_act_reg && fcnt_reg != 3'd7;
    assign fill_end = is_fill && p_act_reg && fcnt_reg == 3'd7;
    assign is_flush = !p_act_reg && cur_reg.command == CMD_FLUSH;
    assign is_access = !p_act_reg && (cur_reg.command inside {CMD_READ, CMD_WRITE});
    assign is_mis = is_access && cur_reg.address[1:0] != 2'b00;
    assign is_hit = is_access && !is_mis && (h0 || h1);
    assign is_miss = is_access && !is_mis && !(h0 || h1);

    // victim: first invalid way, else the lru way
    assign cmp = !valid_reg[l0] || !valid_reg[l1];
    assign vw = !valid_reg[l0] ? 1'b0 : (!valid_reg[l1] ? 1'b1 : lru_reg[cset]);
    assign vl = LINE_W'({cset, vw});
    assign victim_dirty = valid_reg[vl] && dirty_reg[vl];

    assign scan_done = scan_reg == (LINE_W+1)'(LINES);
    assign scan_dirty = valid_reg[sline] && dirty_reg[sline];
    assign wb_end = wbi_reg == 3'd7;

    assign req_ready = st_reg == ST_IDLE && !ov_reg;
    assign out_valid = ov_reg;
    assign kind = ok_reg;
    assign line_address = ola_reg;
    assign data = od_mem_reg ? rd_reg : '0;
    assign hit = oh_reg;
    assign compulsory = oc_reg;
    assign last = ol_reg;

    assign slot_free = !ov_reg || out_ready;

    // dirty lines left after the one being flushed
    always_comb
    begin
        more = 1'b0;
        for (int j = 0; j < LINES; j++)
        begin
            if ((LINE_W+1)'(j) >= scan_reg && valid_reg[j] && dirty_reg[j])
                more = 1'b1;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (req_valid && req_ready) st_next = ST_LOOK;
            ST_LOOK:
            begin
                if (fill_mid) st_next = ST_IDLE;
                else if (fill_end) st_next = ST_FILL_RD;
                else if (is_flush) st_next = ST_FLUSH_SCAN;
                else if (is_miss && victim_dirty) st_next = ST_WB;
                else st_next = ST_OUT;
            end
            ST_FILL_RD: st_next = ST_OUT;
            ST_OUT: if (slot_free) st_next = ST_IDLE;
            ST_FLUSH_SCAN:
            begin
                if (scan_done) st_next = any_reg ? ST_IDLE : ST_OUT;
                else if (scan_dirty) st_next = ST_WB;
            end
            ST_WB:
            begin
                if (slot_free && wb_end) st_next = wb_flush_reg ? ST_FLUSH_SCAN : ST_OUT;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg && !out_ready;
        if ((st_reg inside {ST_OUT, ST_WB}) && slot_free) ov_next = 1'b1;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = cur_reg.write_data;
        mem_re = 1'b0;
        mem_ra = '0;
        case (st_reg)
            ST_LOOK:
            begin
                if (fill_mid || fill_end)
                begin
                    mem_we = 1'b1;
                    mem_wa = WADDR_W'({pline, fcnt_reg});
                end
                else if (is_hit && cur_reg.command == CMD_WRITE)
                begin
                    mem_we = 1'b1;
                    mem_wa = WADDR_W'({hl, cur_reg.address[4:2]});
                end
                else if (is_hit)
                begin
                    mem_re = 1'b1;
                    mem_ra = WADDR_W'({hl, cur_reg.address[4:2]});
                end
            end
            ST_FILL_RD:
            begin
                if (p_wr_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = WADDR_W'({pline, p_addr_reg[4:2]});
                    mem_wd = p_data_reg;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = WADDR_W'({pline, p_addr_reg[4:2]});
                end
            end
            ST_WB:
            begin
                mem_re = slot_free;
                mem_ra = WADDR_W'({wbl_reg, wbi_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready) cur_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            lru_reg <= '0;
            for (int i = 0; i < LINES; i++) tag_reg[i] <= '0;
            p_act_reg <= 1'b0; p_wr_reg <= 1'b0; p_way_reg <= 1'b0;
            p_comp_reg <= 1'b0; p_addr_reg <= '0; p_data_reg <= '0;
            fcnt_reg <= '0;
            wbl_reg <= '0; wbi_reg <= '0; wb_flush_reg <= 1'b0;
            scan_reg <= '0; any_reg <= 1'b0;
            sk_reg <= '0; sla_reg <= '0; sdm_reg <= 1'b0; sh_reg <= 1'b0; sc_reg <= 1'b0;
            ov_reg <= 1'b0; ok_reg <= '0; ola_reg <= '0;
            oh_reg <= 1'b0; oc_reg <= 1'b0; ol_reg <= 1'b0; od_mem_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            case (st_reg)
                ST_LOOK:
                begin
                    if (is_prot)
                    begin
                        sk_reg <= KIND_PROT; sla_reg <= '0; sdm_reg <= 1'b0;
                        sh_reg <= 1'b0; sc_reg <= 1'b0;
                    end
                    else if (fill_mid)
                    begin
                        fcnt_reg <= fcnt_reg + 3'd1;
                    end
                    else if (fill_end)
                    begin
                        fcnt_reg <= '0;
                        p_act_reg <= 1'b0;
                        tag_reg[pline] <= p_addr_reg[15:7];
                        valid_reg[pline] <= 1'b1;
                        dirty_reg[pline] <= p_wr_reg;
                        lru_reg[pset] <= ~p_way_reg;
                    end
                    else if (is_flush)
                    begin
                        scan_reg <= '0; any_reg <= 1'b0;
                    end
                    else if (is_mis)
                    begin
                        sk_reg <= KIND_MIS; sla_reg <= {cur_reg.address[15:5], 5'd0};
                        sdm_reg <= 1'b0; sh_reg <= 1'b0; sc_reg <= 1'b0;
                    end
                    else if (is_hit)
                    begin
                        lru_reg[cset] <= h0;
                        sk_reg <= (cur_reg.command == CMD_WRITE) ? KIND_WDONE : KIND_READ;
                        sla_reg <= {cur_reg.address[15:5], 5'd0};
                        sdm_reg <= cur_reg.command != CMD_WRITE;
                        sh_reg <= 1'b1; sc_reg <= 1'b0;
                        if (cur_reg.command == CMD_WRITE) dirty_reg[hl] <= 1'b1;
                    end
                    else
                    begin
                        // miss: hold the access, write back a dirty victim first
                        p_act_reg <= 1'b1;
                        p_wr_reg <= cur_reg.command == CMD_WRITE;
                        p_addr_reg <= cur_reg.address;
                        p_data_reg <= cur_reg.write_data;
                        p_way_reg <= vw;
                        p_comp_reg <= cmp;
                        fcnt_reg <= '0;
                        valid_reg[vl] <= 1'b0;
                        dirty_reg[vl] <= 1'b0;
                        sk_reg <= KIND_FREQ; sla_reg <= {cur_reg.address[15:5], 5'd0};
                        sdm_reg <= 1'b0; sh_reg <= 1'b0; sc_reg <= cmp;
                        wbl_reg <= vl; wbi_reg <= '0; wb_flush_reg <= 1'b0;
                    end
                end
                ST_FILL_RD:
                begin
                    sk_reg <= p_wr_reg ? KIND_WDONE : KIND_READ;
                    sla_reg <= {p_addr_reg[15:5], 5'd0};
                    sdm_reg <= !p_wr_reg; sh_reg <= 1'b0; sc_reg <= p_comp_reg;
                end
                ST_OUT:
                begin
                    if (slot_free)
                    begin
                        ok_reg <= sk_reg; ola_reg <= sla_reg; od_mem_reg <= sdm_reg;
                        oh_reg <= sh_reg; oc_reg <= sc_reg; ol_reg <= 1'b1;
                    end
                end
                ST_FLUSH_SCAN:
                begin
                    if (scan_done)
                    begin
                        sk_reg <= KIND_FDONE; sla_reg <= '0; sdm_reg <= 1'b0;
                        sh_reg <= 1'b0; sc_reg <= 1'b0;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + (LINE_W+1)'(1);
                        if (scan_dirty)
                        begin
                            dirty_reg[sline] <= 1'b0;
                            wbl_reg <= sline; wbi_reg <= '0; wb_flush_reg <= 1'b1;
                            any_reg <= 1'b1;
                        end
                    end
                end
                ST_WB:
                begin
                    // one word read per cycle while the output slot is free, shown the cycle after
                    if (slot_free)
                    begin
                        ok_reg <= KIND_WB; od_mem_reg <= 1'b1;
                        ola_reg <= {tag_reg[wbl_reg], 2'(wbl_reg[LINE_W-1:1]), 5'd0};
                        oh_reg <= 1'b0; oc_reg <= 1'b0;
                        ol_reg <= wb_flush_reg && wb_end && !more;
                        wbi_reg <= wbi_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg && $stable(ok_reg)) else $error("result dropped");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> st_reg == ST_IDLE) else $error("ready outside idle");
    a_fcnt: assert property (@(posedge clk) disable iff (!rst_n)
        !p_act_reg |-> fcnt_reg == 3'd0) else $error("fill count");
endmodule
`default_nettype wire

// ===== test/two_way_write_back_cache_top_test.sv =====
`timescale 1ns / 100ps
module two_way_write_back_cache_top_test;
    import twc_pkg::*;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    // input channel
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_READ;
    logic [15:0] address = '0;
    logic [31:0] write_data = '0;

    // output channel
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [15:0] line_address;
    logic [31:0] data;
    logic        hit;
    logic        compulsory;
    logic        last;

    two_way_write_back_cache_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .address(address),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .line_address(line_address),
        .data(data),
        .hit(hit),
        .compulsory(compulsory),
        .last(last)
    );

    // one expected result of the cache
    typedef struct {
        logic [2:0]  kind;
        logic [15:0] line_address;
        logic [31:0] data;
        logic        hit;
        logic        compulsory;
        logic        last;
    } cache_result_t;

    cache_result_t expected_results[$];
    int errors = 0;
    bit quiet = 1'b0;       // no idling on either side when set

    // shadow copy of the cache contents
    logic [31:0] shadow_words [WORDS];
    logic [8:0]  shadow_tags  [LINES];
    bit          shadow_valid [LINES];
    bit          shadow_dirty [LINES];
    bit          shadow_lru   [SETS];
    bit          miss_pending = 1'b0;
    bit          miss_is_write = 1'b0;
    logic [15:0] miss_addr = '0;
    logic [31:0] miss_data = '0;
    bit          miss_way = 1'b0;
    bit          miss_comp = 1'b0;
    int          fills_seen = 0;

    task automatic push_result(input logic [2:0] k, input logic [15:0] la,
                               input logic [31:0] d, input logic h, input logic c);
        cache_result_t r;
        r.kind = k;
        r.line_address = la;
        r.data = d;
        r.hit = h;
        r.compulsory = c;
        r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    // stream a dirty victim line out as eight words
    task automatic push_writeback(input int s, input int w);
        int ln;
        logic [15:0] la;
        ln = s * WAYS + w;
        la = {shadow_tags[ln], 2'(s), 5'd0};
        for (int i = 0; i < LINE_WORDS; i++)
            push_result(KIND_WB, la, shadow_words[ln * LINE_WORDS + i], 1'b0, 1'b0);
    endtask

    // work out every result that one accepted transaction causes
    task automatic predict_cache(input logic [1:0] cmd, input logic [15:0] addr,
                                 input logic [31:0] wd);
        int start_count;
        int s;
        int ln;
        int found;
        int way;
        bit comp;
        logic [15:0] la;
        start_count = expected_results.size();
        s = int'(addr[6:5]);
        la = {addr[15:5], 5'd0};
        if (cmd == CMD_FILL)
        begin
            if (!miss_pending)
                push_result(KIND_PROT, '0, '0, 1'b0, 1'b0);
            else
            begin
                s = int'(miss_addr[6:5]);
                ln = s * WAYS + int'(miss_way);
                shadow_words[ln * LINE_WORDS + fills_seen] = wd;
                if (fills_seen < LINE_WORDS - 1)
                    fills_seen++;
                else
                begin
                    fills_seen = 0;
                    miss_pending = 1'b0;
                    shadow_tags[ln] = miss_addr[15:7];
                    shadow_valid[ln] = 1'b1;
                    shadow_lru[s] = ~miss_way;
                    if (miss_is_write)
                    begin
                        shadow_words[ln * LINE_WORDS + int'(miss_addr[4:2])] = miss_data;
                        shadow_dirty[ln] = 1'b1;
                        push_result(KIND_WDONE, {miss_addr[15:5], 5'd0}, '0, 1'b0,
                                    miss_comp);
                    end
                    else
                    begin
                        shadow_dirty[ln] = 1'b0;
                        push_result(KIND_READ, {miss_addr[15:5], 5'd0},
                                    shadow_words[ln * LINE_WORDS + int'(miss_addr[4:2])],
                                    1'b0, miss_comp);
                    end
                end
            end
        end
        else if (miss_pending)
            push_result(KIND_PROT, '0, '0, 1'b0, 1'b0);
        else if (cmd == CMD_FLUSH)
        begin
            for (int fs = 0; fs < SETS; fs++)
                for (int fw = 0; fw < WAYS; fw++)
                    if (shadow_valid[fs * WAYS + fw] && shadow_dirty[fs * WAYS + fw])
                    begin
                        push_writeback(fs, fw);
                        shadow_dirty[fs * WAYS + fw] = 1'b0;
                    end
            if (expected_results.size() == start_count)
                push_result(KIND_FDONE, '0, '0, 1'b0, 1'b0);
        end
        else if (addr[1:0] != 2'd0)
            push_result(KIND_MIS, la, '0, 1'b0, 1'b0);
        else
        begin
            found = -1;
            for (int w = 0; w < WAYS; w++)
                if (found < 0 && shadow_valid[s * WAYS + w]
                    && shadow_tags[s * WAYS + w] == addr[15:7])
                    found = w;
            if (found >= 0)
            begin
                ln = s * WAYS + found;
                shadow_lru[s] = ~found[0];
                if (cmd == CMD_WRITE)
                begin
                    shadow_words[ln * LINE_WORDS + int'(addr[4:2])] = wd;
                    shadow_dirty[ln] = 1'b1;
                    push_result(KIND_WDONE, la, '0, 1'b1, 1'b0);
                end
                else
                    push_result(KIND_READ, la,
                                shadow_words[ln * LINE_WORDS + int'(addr[4:2])],
                                1'b1, 1'b0);
            end
            else
            begin
                // first invalid way, else the lru way
                way = int'(shadow_lru[s]);
                comp = 1'b0;
                for (int w = WAYS - 1; w >= 0; w--)
                    if (!shadow_valid[s * WAYS + w])
                    begin
                        way = w;
                        comp = 1'b1;
                    end
                ln = s * WAYS + way;
                if (shadow_valid[ln] && shadow_dirty[ln])
                    push_writeback(s, way);
                shadow_valid[ln] = 1'b0;
                shadow_dirty[ln] = 1'b0;
                miss_pending = 1'b1;
                miss_is_write = (cmd == CMD_WRITE);
                miss_addr = addr;
                miss_data = wd;
                miss_way = way[0];
                miss_comp = comp;
                fills_seen = 0;
                push_result(KIND_FREQ, la, '0, 1'b0, comp);
            end
        end
        if (expected_results.size() > start_count)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // send one transaction, with an optional random gap in front
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [31:0] wd);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        write_data <= wd;
        do
            @(posedge clk);
        while (!in_ready);
        predict_cache(cmd, addr, wd);
    endtask

    // small tag pool so that hits, dirty evictions and reuse are common
    function automatic logic [15:0] pick_address();
        logic [8:0] t;
        case ($urandom_range(0, 5))
            0: t = 9'h000;
            1: t = 9'h1ff;
            2: t = 9'h001;
            3: t = 9'h0aa;
            default: t = 9'($urandom_range(0, 511));
        endcase
        return {t, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 2'b00};
    endfunction

    // an access plus the line fill that a miss asks for
    task automatic access_and_fill(input logic [1:0] cmd, input logic [15:0] addr,
                                   input logic [31:0] wd);
        send_item(cmd, addr, wd);
        while (miss_pending)
            send_item(CMD_FILL, 16'($urandom), $urandom);
    endtask

    task automatic test_directed();
        send_item(CMD_FLUSH, 16'h0000, '0);                  // empty flush
        send_item(CMD_FILL, 16'hffff, 32'hffff_ffff);        // fill with none pending
        send_item(CMD_READ, 16'hffff, '0);                   // misaligned
        send_item(CMD_WRITE, 16'h0001, 32'hffff_ffff);       // misaligned
        send_item(CMD_READ, 16'h0000, '0);                   // compulsory miss
        send_item(CMD_READ, 16'h0004, '0);                   // access during fill
        send_item(CMD_FLUSH, 16'h0000, '0);                  // flush during fill
        for (int i = 0; i < LINE_WORDS; i++)
            send_item(CMD_FILL, 16'($urandom), (i[0]) ? 32'hffff_ffff : 32'h0);
        send_item(CMD_READ, 16'h001c, '0);                   // read hit
        send_item(CMD_WRITE, 16'h0008, 32'hffff_ffff);       // write hit
        access_and_fill(CMD_WRITE, 16'hfffc, 32'h0);         // compulsory write miss
        access_and_fill(CMD_READ, 16'h0080, '0);             // compulsory miss into the free way
        send_item(CMD_FLUSH, 16'hffff, 32'hffff_ffff);       // flush dirty lines
    endtask

    task automatic test_random(input int count);
        int n;
        logic [15:0] a;
        n = 0;
        while (n < count)
        begin
            a = pick_address();
            case ($urandom_range(0, 19))
                0: send_item(CMD_FILL, 16'($urandom), $urandom);
                1: send_item(CMD_FLUSH, 16'($urandom), $urandom);
                2: send_item(2'($urandom_range(0, 1)), a | 16'($urandom_range(1, 3)),
                             $urandom);
                3:
                begin
                    // broken sequence: interrupt a pending fill
                    send_item(2'($urandom_range(0, 1)), a, $urandom);
                    if (miss_pending)
                    begin
                        send_item(CMD_FILL, 16'($urandom), $urandom);
                        send_item(2'($urandom_range(0, 3)) & 2'b01 | 2'b00, a, $urandom);
                    end
                    while (miss_pending)
                        send_item(CMD_FILL, 16'($urandom), $urandom);
                end
                default: access_and_fill(2'($urandom_range(0, 1)), a, $urandom);
            endcase
            n++;
        end
    endtask

    task automatic test_quiet();
        quiet = 1'b1;
        test_random(15);
        send_item(CMD_FLUSH, '0, '0);
    endtask

    // receiver with random stall bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d", kind));
            else
            begin
                cache_result_t e;
                e = expected_results.pop_front();
                if (kind !== e.kind || line_address !== e.line_address
                    || data !== e.data || hit !== e.hit
                    || compulsory !== e.compulsory || last !== e.last)
                    report_mismatch($sformatf(
                        "got k%0d la%h d%h h%b c%b l%b want k%0d la%h d%h h%b c%b l%b",
                        kind, line_address, data, hit, compulsory, last,
                        e.kind, e.line_address, e.data, e.hit, e.compulsory, e.last));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < WORDS; i++)
            shadow_words[i] = '0;
        for (int i = 0; i < LINES; i++)
        begin
            shadow_tags[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
        end
        for (int i = 0; i < SETS; i++)
            shadow_lru[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(25);
        test_quiet();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("two_way_write_back_cache_top verification clean");
        else
            $display("two_way_write_back_cache_top verification failed");
        $finish;
    end

    // overall time limit
    initial
    begin
        #1000000;
        $display("two_way_write_back_cache_top verification failed");
        $finish;
    end
endmodule
